### rtl/core/ghst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghst_pkg;

  localparam int SLOTS  = 1024;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int IDX_W  = 10;
  localparam int ID_W   = 64;
  localparam int PAY_W  = 32;

  localparam logic [ID_W-1:0] REMOVAL_MARK = '1;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_SWEEP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    action_t          action;
    logic [IDX_W-1:0] slot_index;
    logic [ID_W-1:0]  handle_id;
    logic [PAY_W-1:0] payload;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] out_index;
    logic [ID_W-1:0]  out_id;
    logic [PAY_W-1:0] out_payload;
  } out_res_t;

  typedef struct packed {
    logic             occupied;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } slot_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    slot_t             data;
  } ram_wr_t;

endpackage

`default_nettype wire

### rtl/core/ghst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ghst_ram (
  input  logic                      clk,
  input  ghst_pkg::ram_wr_t         wr,
  input  logic [ghst_pkg::ADDR_W-1:0] raddr,
  output ghst_pkg::slot_t           rdata
);
  import ghst_pkg::*;

  slot_t mem [SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/ghst_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module ghst_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ghst_pkg::in_req_t           in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ghst_pkg::out_res_t          res,
  output ghst_pkg::ram_wr_t           wr,
  output logic [ghst_pkg::ADDR_W-1:0] raddr,
  input  ghst_pkg::slot_t             rdata
);
  import ghst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_GET,
    S_MARK,
    S_SWEEP,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  free_ptr_r, free_ptr_nxt;
  logic [ID_W-1:0]   ctr_r, ctr_nxt;
  in_req_t           req_r, req_nxt;
  out_res_t          res_r, res_nxt;
  logic [ID_W-1:0]   id_inc;
  logic              in_idx_ok;
  logic [ADDR_W-1:0] in_addr;

  assign id_inc    = ctr_r + ID_W'(1);
  assign in_idx_ok = 32'(in_data.slot_index) < SLOTS;
  assign in_addr   = ADDR_W'(in_data.slot_index);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    free_ptr_nxt = free_ptr_r;
    ctr_nxt      = ctr_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    wr           = '0;
    raddr        = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = ptr_r[ADDR_W-1:0];
        if (ptr_r == CNT_W'(SLOTS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          case (in_data.action)
            ACT_ADD: begin
              if (free_ptr_r == CNT_W'(SLOTS)) begin
                res_nxt.status = STS_FULL;
                state_nxt      = S_RESP;
              end else begin
                raddr     = free_ptr_r[ADDR_W-1:0];
                state_nxt = S_ADD;
              end
            end
            ACT_GET: begin
              res_nxt.status = STS_NOT_FOUND;
              if (in_idx_ok) begin
                raddr     = in_addr;
                state_nxt = S_GET;
              end else begin
                state_nxt = S_RESP;
              end
            end
            ACT_MARK: begin
              if (in_idx_ok) begin
                raddr     = in_addr;
                state_nxt = S_MARK;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              raddr     = '0;
              ptr_nxt   = '0;
              state_nxt = S_SWEEP;
            end
          endcase
        end
      end
      S_ADD: begin
        if (!rdata.occupied) begin
          ctr_nxt            = id_inc;
          wr.we              = 1'b1;
          wr.addr            = free_ptr_r[ADDR_W-1:0];
          wr.data.occupied   = 1'b1;
          wr.data.id         = id_inc;
          wr.data.payload    = req_r.payload;
          res_nxt.status     = STS_OK;
          res_nxt.out_index  = IDX_W'(free_ptr_r[ADDR_W-1:0]);
          res_nxt.out_id     = id_inc;
          free_ptr_nxt       = free_ptr_r + CNT_W'(1);
          state_nxt          = S_RESP;
        end else if (free_ptr_r == CNT_W'(SLOTS - 1)) begin
          free_ptr_nxt   = CNT_W'(SLOTS);
          res_nxt.status = STS_FULL;
          state_nxt      = S_RESP;
        end else begin
          free_ptr_nxt = free_ptr_r + CNT_W'(1);
          raddr        = free_ptr_nxt[ADDR_W-1:0];
        end
      end
      S_GET: begin
        if (rdata.occupied && rdata.id != REMOVAL_MARK && rdata.id == req_r.handle_id) begin
          res_nxt.status      = STS_OK;
          res_nxt.out_payload = rdata.payload;
        end
        state_nxt = S_RESP;
      end
      S_MARK: begin
        if (rdata.occupied) begin
          wr.we            = 1'b1;
          wr.addr          = ADDR_W'(req_r.slot_index);
          wr.data.occupied = 1'b1;
          wr.data.id       = REMOVAL_MARK;
          wr.data.payload  = rdata.payload;
        end
        state_nxt = S_RESP;
      end
      S_SWEEP: begin
        if (rdata.occupied && rdata.id == REMOVAL_MARK) begin
          wr.we   = 1'b1;
          wr.addr = ptr_r[ADDR_W-1:0];
          if (ptr_r < free_ptr_r) begin
            free_ptr_nxt = ptr_r;
          end
        end
        if (ptr_r == CNT_W'(SLOTS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
          raddr   = ptr_nxt[ADDR_W-1:0];
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      ptr_r      <= '0;
      free_ptr_r <= '0;
      ctr_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      free_ptr_r <= free_ptr_nxt;
      ctr_r      <= ctr_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    free_ptr_r <= CNT_W'(SLOTS))
    else $error("free slot pointer beyond the table");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && wr.we) |=> (ctr_r == $past(wr.data.id)))
    else $error("stored id differs from the id counter");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && wr.we) |->
      (wr.addr == ptr_r[ADDR_W-1:0] && !wr.data.occupied))
    else $error("sweep write does not free the swept slot");

  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_r)))
    else $error("result dropped or changed while stalled");

endmodule

`default_nettype wire

### rtl/core/generational_handle_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot table handing out generation-checked handles, with all slot state in one
// single-port-read synchronous RAM that reads one entry per cycle. After reset
// the block runs a clearing pass, one slot per cycle, before it takes its first
// request. A get or a mark reads its slot from the RAM and then presents its
// result; the next request can be accepted once that result has moved into the
// output register. An add probes the slots upward from the lowest slot that may
// be free and skips each occupied slot, so an add into a table filled in order
// takes the first slot that it probes. An add into a table already known to be
// full answers without reading the table. A sweep walks every slot once before
// it presents its result. The next request is accepted while a result still
// waits in the output register.
module generational_handle_slot_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ghst_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ghst_pkg::out_res_t out_data
);
  import ghst_pkg::*;

  logic              res_valid;
  logic              res_ready;
  out_res_t          res;
  ram_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  slot_t             rdata;

  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  ghst_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  ghst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr        (wr),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### dv/ghst_checker.sv
`timescale 1ns / 1ps

module ghst_checker
  import ghst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_res_t out_data,
  output int       fail_count,
  output int       pending
);

  logic             occupied   [SLOTS];
  logic [ID_W-1:0]  stored_id  [SLOTS];
  logic [PAY_W-1:0] stored_pay [SLOTS];
  logic [ID_W-1:0]  id_counter;
  out_res_t         queued_replies [$];

  function automatic out_res_t table_reply(in_req_t req);
    out_res_t rep;
    int slot;
    bit found;
    rep = '0;
    rep.status = STS_OK;
    found = 1'b0;
    case (req.action)
      ACT_ADD: begin
        rep.status = STS_FULL;
        for (slot = 0; slot < SLOTS; slot++) begin
          if (!found && !occupied[slot]) begin
            found = 1'b1;
            id_counter = id_counter + 1'b1;
            occupied[slot] = 1'b1;
            stored_id[slot] = id_counter;
            stored_pay[slot] = req.payload;
            rep.status = STS_OK;
            rep.out_index = IDX_W'(slot);
            rep.out_id = id_counter;
          end
        end
      end
      ACT_GET: begin
        rep.status = STS_NOT_FOUND;
        if (int'(req.slot_index) < SLOTS && occupied[req.slot_index] &&
            stored_id[req.slot_index] != REMOVAL_MARK &&
            stored_id[req.slot_index] == req.handle_id) begin
          rep.status = STS_OK;
          rep.out_payload = stored_pay[req.slot_index];
        end
      end
      ACT_MARK: begin
        if (int'(req.slot_index) < SLOTS && occupied[req.slot_index]) begin
          stored_id[req.slot_index] = REMOVAL_MARK;
        end
      end
      ACT_SWEEP: begin
        for (slot = 0; slot < SLOTS; slot++) begin
          if (occupied[slot] && stored_id[slot] == REMOVAL_MARK) begin
            occupied[slot] = 1'b0;
            stored_id[slot] = '0;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    out_res_t exp_rep;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        occupied[s] = 1'b0;
        stored_id[s] = '0;
        stored_pay[s] = '0;
      end
      id_counter = '0;
      queued_replies.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (queued_replies.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: status=%0d index=%0d id=%h payload=%h",
                     out_data.status, out_data.out_index, out_data.out_id,
                     out_data.out_payload);
          end
          fail_count++;
        end else begin
          exp_rep = queued_replies.pop_front();
          if (out_data.status !== exp_rep.status ||
              out_data.out_index !== exp_rep.out_index ||
              out_data.out_id !== exp_rep.out_id ||
              out_data.out_payload !== exp_rep.out_payload) begin
            if (fail_count < 10) begin
              $display("mismatch: expected status=%0d index=%0d id=%h payload=%h",
                       exp_rep.status, exp_rep.out_index, exp_rep.out_id,
                       exp_rep.out_payload);
              $display("          actual   status=%0d index=%0d id=%h payload=%h",
                       out_data.status, out_data.out_index, out_data.out_id,
                       out_data.out_payload);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        queued_replies.push_back(table_reply(in_data));
      end
    end
    pending = queued_replies.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ghst_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int written_top = 0;
  logic [ID_W-1:0] last_id [SLOTS];

  generational_handle_slot_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ghst_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Handles that the block hands out are kept so that later requests can use them.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.status == STS_OK &&
        out_data.out_id != '0) begin
      last_id[out_data.out_index] <= out_data.out_id;
      if (int'(out_data.out_index) + 1 > written_top) begin
        written_top <= int'(out_data.out_index) + 1;
      end
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PAY_W-1:0] rand_pay();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot();
    return IDX_W'($urandom_range(0, written_top - 1));
  endfunction

  task automatic send_req(action_t act, logic [IDX_W-1:0] idx,
                          logic [ID_W-1:0] hid, logic [PAY_W-1:0] pay);
    in_req_t req;
    req.action = act;
    req.slot_index = idx;
    req.handle_id = hid;
    req.payload = pay;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic add_burst();
    repeat ($urandom_range(1, 4)) begin
      send_req(ACT_ADD, IDX_W'($urandom), rand_id(), rand_pay());
    end
  endtask

  task automatic get_handle();
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0] hid;
    int pick;
    idx = pick_slot();
    pick = $urandom_range(0, 99);
    if (pick < 60) hid = last_id[idx];
    else if (pick < 75) hid = last_id[idx] ^ (64'd1 << $urandom_range(0, 63));
    else if (pick < 85) hid = REMOVAL_MARK;
    else hid = rand_id();
    send_req(ACT_GET, idx, hid, rand_pay());
  endtask

  task automatic mark_burst();
    repeat ($urandom_range(1, 6)) begin
      send_req(ACT_MARK, pick_slot(), rand_id(), rand_pay());
    end
    if ($urandom_range(0, 1) == 1) begin
      send_req(ACT_SWEEP, IDX_W'($urandom), rand_id(), rand_pay());
    end
  endtask

  task automatic noise_req();
    action_t act;
    act = action_t'($urandom_range(0, 3));
    send_req(act, (act == ACT_GET || act == ACT_MARK) ? pick_slot() : IDX_W'($urandom),
             rand_id(), $urandom);
  endtask

  task automatic fill_table();
    repeat (SLOTS + 1) begin
      send_req(ACT_ADD, IDX_W'($urandom), rand_id(), rand_pay());
    end
    wait_drained();
    send_req(ACT_GET, IDX_W'(SLOTS - 1), last_id[SLOTS-1], '0);
    send_req(ACT_MARK, IDX_W'(SLOTS - 1), '0, '0);
    send_req(ACT_GET, IDX_W'(SLOTS - 1), last_id[SLOTS-1], '0);
    send_req(ACT_ADD, '0, '0, '1);
    repeat (6) begin
      send_req(ACT_MARK, pick_slot(), rand_id(), rand_pay());
    end
    send_req(ACT_SWEEP, '1, '1, '1);
    send_req(ACT_GET, IDX_W'(SLOTS - 1), last_id[SLOTS-1], '0);
  endtask

  task automatic random_phase(int tx_pct, int rx_pct, int n_req);
    int target;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    wait_drained();
    target = sent_count + n_req;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) add_burst();
      else if (pick < 60) get_handle();
      else if (pick < 85) mark_burst();
      else noise_req();
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) last_id[s] = '0;
    tx_idle_pct = 34;
    rx_idle_pct = 86;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(ACT_ADD, '0, '0, '0);
    send_req(ACT_ADD, '1, '1, '1);
    send_req(ACT_ADD, '0, '0, 32'h5a5a_5a5a);
    send_req(ACT_GET, 10'd0, 64'd1, '0);
    send_req(ACT_GET, 10'd1, 64'd2, '0);
    send_req(ACT_GET, 10'd1, 64'd3, '0);
    send_req(ACT_GET, 10'd2, REMOVAL_MARK, '0);
    send_req(ACT_MARK, 10'd1, '0, '0);
    send_req(ACT_GET, 10'd1, REMOVAL_MARK, '0);
    send_req(ACT_GET, 10'd1, 64'd2, '0);
    send_req(ACT_ADD, '0, '0, 32'd1);
    send_req(ACT_SWEEP, '0, '0, '0);
    send_req(ACT_GET, 10'd1, '0, '0);
    send_req(ACT_GET, 10'd1, 64'd2, '0);
    send_req(ACT_MARK, 10'd1, '1, '1);
    send_req(ACT_ADD, '0, '0, 32'h8000_0000);
    send_req(ACT_GET, 10'd1, 64'd5, '0);
    send_req(ACT_GET, 10'd3, 64'd4, '0);
    send_req(ACT_GET, 10'd2, 64'd3, '1);
    send_req(ACT_SWEEP, '1, '1, '1);

    fill_table();
    random_phase(34, 86, 8);
    random_phase(86, 34, 8);
    random_phase(0, 0, 8);

    wait_drained();
    repeat (32) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### generational_handle_slot_table.f
rtl/core/ghst_pkg.sv
rtl/core/ghst_ram.sv
rtl/core/ghst_engine.sv
rtl/core/generational_handle_slot_table.sv
dv/ghst_checker.sv
dv/tb.sv
